// File: src/srtf_preemptive_scheduler_assert.svh
// ---------------------------------------------------------------------------
// srtf assertion macros
// shared concurrent check templates, clocked on clk, off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_ASSERT_SVH

// condition holds at every edge
`define SRTF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("srtf: invariant violated");

// consequent holds in the cycle after the antecedent
`define SRTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srtf: next-cycle check failed");

`endif

// File: src/srtf_pkg.sv
// ---------------------------------------------------------------------------
// srtf_pkg
// shared constants and controller/datapath types for the srtf scheduler
// ---------------------------------------------------------------------------
package srtf_pkg;

  localparam int MAX_JOBS = 16;
  localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
  } slot_t;

  typedef struct packed {
    logic              add;
    logic              clear;
    logic              scan_clr;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              upd;
    logic              res_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: src/srtf_if.sv
// ---------------------------------------------------------------------------
// srtf channel interfaces
// valid/ready channels for scheduler requests and tick results
// ---------------------------------------------------------------------------
interface srtf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  job_id;
  logic [31:0] arrival;
  logic [15:0] burst;

  modport source (output valid, operation, job_id, arrival, burst, input ready);
  modport sink   (input valid, operation, job_id, arrival, burst, output ready);
endinterface

interface srtf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  ran_id;
  logic        idle;
  logic        switched;
  logic        finished;
  logic [31:0] done_time;
  logic [31:0] turnaround;
  logic [31:0] waiting;
  logic        all_done;
  logic [31:0] time_now;

  modport source (output valid, ran_id, idle, switched, finished, done_time,
                  turnaround, waiting, all_done, time_now, input ready);
  modport sink   (input valid, ran_id, idle, switched, finished, done_time,
                  turnaround, waiting, all_done, time_now, output ready);
endinterface

// File: src/srtf_preemptive_scheduler.sv
// ---------------------------------------------------------------------------
// srtf_preemptive_scheduler
// preemptive shortest-remaining-time-first scheduler over a 16-slot job table
//
// requests enter on in_ch (valid/ready): add stores a job in the next free
// slot (dropped when the table is full), clear empties the table and zeroes
// time, tick runs one time unit. only ticks produce a beat on out_ch.
// in_ch.ready is high only while the sequencer is idle, so one request is
// worked on at a time. add, clear and unused codes are handled in idle.
// a tick walks the table one slot per cycle through a single memory port
// into one shared comparator, then compares the last entry in a drain step,
// followed by an update step and a result step that loads out_ch; the next
// request is taken only after the sequencer is back in idle.
// results sit in an output register; further adds and clears are taken while
// it waits. a tick reaching the result step while out_ch is stalled holds
// there until the register frees.
// after reset (rst_n low, synchronous) the table is empty, time is zero and
// no previous job is recorded; slot storage itself is not cleared.
// ---------------------------------------------------------------------------
module srtf_preemptive_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  srtf_in_if.sink    in_ch,
  srtf_out_if.source out_ch
);
  import srtf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srtf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .cmd          (cmd),
    .sts          (sts)
  );

  srtf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_job_id       (in_ch.job_id),
    .in_arrival      (in_ch.arrival),
    .in_burst        (in_ch.burst),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_ran_id      (out_ch.ran_id),
    .out_idle        (out_ch.idle),
    .out_switched    (out_ch.switched),
    .out_finished    (out_ch.finished),
    .out_done_time   (out_ch.done_time),
    .out_turnaround  (out_ch.turnaround),
    .out_waiting     (out_ch.waiting),
    .out_all_done    (out_ch.all_done),
    .out_time_now    (out_ch.time_now)
  );

endmodule

// File: src/srtf_ctrl.sv
// ---------------------------------------------------------------------------
// srtf_ctrl
// sequencer: decodes requests, walks the slot table, then update and result
// ---------------------------------------------------------------------------
module srtf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  output srtf_pkg::cmd_t   cmd,
  input  srtf_pkg::sts_t   sts
);
  import srtf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD,
    ST_RES
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] scan_r, scan_nxt;
  logic              accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    scan_nxt     = scan_r;
    cmd          = '0;
    cmd.rd_addr  = scan_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_ADD:   cmd.add = 1'b1;
            OP_CLEAR: cmd.clear = 1'b1;
            OP_TICK: begin
              cmd.scan_clr = 1'b1;
              scan_nxt     = '0;
              state_nxt    = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (scan_r == SLOT_W'(MAX_JOBS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      // last read entry is compared here
      ST_DRAIN: state_nxt = ST_UPD;
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

endmodule

// File: src/srtf_dp.sv
// ---------------------------------------------------------------------------
// srtf_dp
// slot memory, running best-candidate compare, counters and result register
// ---------------------------------------------------------------------------
`include "srtf_preemptive_scheduler_assert.svh"

module srtf_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  srtf_pkg::cmd_t   cmd,
  output srtf_pkg::sts_t   sts,
  input  logic [7:0]       in_job_id,
  input  logic [31:0]      in_arrival,
  input  logic [15:0]      in_burst,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_ran_id,
  output logic             out_idle,
  output logic             out_switched,
  output logic             out_finished,
  output logic [31:0]      out_done_time,
  output logic [31:0]      out_turnaround,
  output logic [31:0]      out_waiting,
  output logic             out_all_done,
  output logic [31:0]      out_time_now
);
  import srtf_pkg::*;

  slot_t             slot_mem_r [MAX_JOBS];
  slot_t             rd_q_r;
  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_idx_r;

  logic [CNT_W-1:0]  job_cnt_r, done_cnt_r;
  logic [31:0]       time_r, time_nxt;
  logic [7:0]        last_ran_r;
  logic              last_vld_r;

  slot_t             best_r;
  logic [SLOT_W-1:0] best_slot_r;
  logic              best_found_r;

  logic              res_idle_r, res_sw_r, res_fin_r;
  logic [7:0]        res_id_r;
  logic [31:0]       res_tat_r;
  logic [15:0]       res_burst_r;

  logic              out_valid_r, out_idle_r, out_sw_r, out_fin_r, out_done_r;
  logic [7:0]        out_ran_r;
  logic [31:0]       out_ftime_r, out_tat_r, out_wait_r, out_time_r;

  logic              table_full, add_ok, eligible, better;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  slot_t             mem_wd;
  logic [15:0]       rem_dec;
  logic [31:0]       wait_val;

  assign table_full = (job_cnt_r == CNT_W'(MAX_JOBS));
  assign add_ok     = cmd.add && !table_full;
  assign rem_dec    = best_r.remaining - 16'd1;
  assign time_nxt   = (time_r == TIME_MAX) ? time_r : time_r + 32'd1;

  // candidate check on the entry read in the previous cycle
  assign eligible = rd_vld_r && (CNT_W'(rd_idx_r) < job_cnt_r) &&
                    (rd_q_r.remaining != 16'd0) && (rd_q_r.arrival <= time_r);
  assign better   = !best_found_r || (rd_q_r.remaining < best_r.remaining) ||
                    ((rd_q_r.remaining == best_r.remaining) && (rd_q_r.id < best_r.id));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = job_cnt_r[SLOT_W-1:0];
    mem_wd = '{id: in_job_id, arrival: in_arrival, burst: in_burst, remaining: in_burst};
    if (add_ok) begin
      mem_we = 1'b1;
    end else if (cmd.upd && best_found_r) begin
      mem_we           = 1'b1;
      mem_wa           = best_slot_r;
      mem_wd           = best_r;
      mem_wd.remaining = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem_r[mem_wa] <= mem_wd;
    if (cmd.rd_en) rd_q_r <= slot_mem_r[cmd.rd_addr];
  end

  assign wait_val = (res_tat_r >= {16'd0, res_burst_r}) ?
                    res_tat_r - {16'd0, res_burst_r} : 32'd0;

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= cmd.rd_addr;
    if (eligible && better) begin
      best_r      <= rd_q_r;
      best_slot_r <= rd_idx_r;
    end
    if (cmd.upd) begin
      res_idle_r  <= !best_found_r;
      res_id_r    <= best_r.id;
      res_sw_r    <= !last_vld_r || (last_ran_r != best_r.id);
      res_fin_r   <= best_found_r && (rem_dec == 16'd0);
      res_tat_r   <= time_nxt - best_r.arrival;
      res_burst_r <= best_r.burst;
    end
    if (cmd.res_load) begin
      out_idle_r  <= res_idle_r;
      out_ran_r   <= res_idle_r ? 8'd0 : res_id_r;
      out_sw_r    <= !res_idle_r && res_sw_r;
      out_fin_r   <= res_fin_r;
      out_ftime_r <= res_fin_r ? time_r : 32'd0;
      out_tat_r   <= res_fin_r ? res_tat_r : 32'd0;
      out_wait_r  <= res_fin_r ? wait_val : 32'd0;
      out_done_r  <= (done_cnt_r == job_cnt_r);
      out_time_r  <= time_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      job_cnt_r    <= '0;
      done_cnt_r   <= '0;
      time_r       <= '0;
      last_ran_r   <= '0;
      last_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.scan_clr) begin
        best_found_r <= 1'b0;
      end else if (eligible) begin
        best_found_r <= 1'b1;
      end
      if (cmd.clear) begin
        job_cnt_r  <= '0;
        done_cnt_r <= '0;
        time_r     <= '0;
        last_ran_r <= '0;
        last_vld_r <= 1'b0;
      end else if (add_ok) begin
        job_cnt_r <= job_cnt_r + 1'b1;
        if (in_burst == 16'd0) done_cnt_r <= done_cnt_r + 1'b1;
      end else if (cmd.upd) begin
        time_r <= time_nxt;
        if (best_found_r) begin
          last_ran_r <= best_r.id;
          last_vld_r <= 1'b1;
          if (rem_dec == 16'd0) done_cnt_r <= done_cnt_r + 1'b1;
        end
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_ran_id      = out_ran_r;
  assign out_idle        = out_idle_r;
  assign out_switched    = out_sw_r;
  assign out_finished    = out_fin_r;
  assign out_done_time   = out_ftime_r;
  assign out_turnaround  = out_tat_r;
  assign out_waiting     = out_wait_r;
  assign out_all_done    = out_done_r;
  assign out_time_now    = out_time_r;

  `SRTF_ASSERT_ALWAYS(a_done_le_jobs, done_cnt_r <= job_cnt_r)
  `SRTF_ASSERT_ALWAYS(a_jobs_le_max, job_cnt_r <= CNT_W'(MAX_JOBS))
  `SRTF_ASSERT_NEXT(a_clear_empties, cmd.clear, job_cnt_r == '0 && time_r == '0)
  `SRTF_ASSERT_ALWAYS(a_idle_no_job, !(out_valid_r && out_idle_r) || (out_ran_r == '0 && !out_fin_r))

endmodule

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the srtf scheduler: a short directed sequence, then
// random job sets run to completion plus full-range noise, with random gaps
// and stalls on both channels and long output hold-offs
// ---------------------------------------------------------------------------
module tb_top;
  import srtf_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         NUM_ITEMS   = 1600;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         DRAIN_LIMIT = 20000;
  localparam int         HOLD_CYCLES = 320;
  localparam int         MAX_PRINTS  = 30;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [15:0] burst;
    bit          drain_first;
  } sched_req_t;

  typedef struct packed {
    logic [7:0]  ran_id;
    logic        idle;
    logic        switched;
    logic        finished;
    logic [31:0] done_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        all_done;
    logic [31:0] time_now;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  srtf_in_if  in_ch ();
  srtf_out_if out_ch ();

  srtf_preemptive_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // job table as the scheduler should see it
  logic [7:0]  job_id_tbl    [MAX_JOBS];
  logic [31:0] job_arr_tbl   [MAX_JOBS];
  logic [15:0] job_burst_tbl [MAX_JOBS];
  logic [15:0] job_left_tbl  [MAX_JOBS];
  int          jobs_loaded = 0;
  int          jobs_done   = 0;
  logic [31:0] sched_time  = '0;
  logic [7:0]  prev_ran_id = '0;
  bit          prev_ran_valid = 1'b0;

  sched_req_t   pending_reqs [$];
  tick_result_t expected_ticks [$];
  sched_req_t   cur_req;

  int items_accepted = 0;
  int ticks_checked  = 0;
  int idle_ticks     = 0;
  int completions    = 0;
  int adds_dropped   = 0;
  int err_count      = 0;
  int cycle_count    = 0;
  int send_gap       = 0;
  int recv_wait      = 0;
  int hold_left      = 0;
  int holds_done     = 0;
  bit send_steady    = 1'b0;
  bit recv_steady    = 1'b0;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("tick result %0d %s: got %0h expected %0h",
                                ticks_checked, name, got, want));
  endtask

  // update the job table for one accepted beat, queue the tick result
  task automatic apply_request(input sched_req_t r);
    int pick;
    int s;
    tick_result_t res;
    logic [31:0] span;
    case (r.op)
      OP_ADD: begin
        if (jobs_loaded < MAX_JOBS) begin
          job_id_tbl[jobs_loaded]    = r.id;
          job_arr_tbl[jobs_loaded]   = r.arrival;
          job_burst_tbl[jobs_loaded] = r.burst;
          job_left_tbl[jobs_loaded]  = r.burst;
          jobs_loaded++;
          if (r.burst == 16'd0) jobs_done++;
        end else begin
          adds_dropped++;
        end
      end
      OP_CLEAR: begin
        jobs_loaded    = 0;
        jobs_done      = 0;
        sched_time     = '0;
        prev_ran_id    = '0;
        prev_ran_valid = 1'b0;
      end
      OP_TICK: begin
        pick = -1;
        for (s = 0; s < jobs_loaded; s++) begin
          if (job_left_tbl[s] == 16'd0 || job_arr_tbl[s] > sched_time) continue;
          // strict compare keeps the lowest slot on a full tie
          if (pick < 0 || job_left_tbl[s] < job_left_tbl[pick] ||
              (job_left_tbl[s] == job_left_tbl[pick] &&
               job_id_tbl[s] < job_id_tbl[pick]))
            pick = s;
        end
        if (sched_time != TIME_MAX) sched_time = sched_time + 32'd1;
        res = '0;
        res.idle = 1'b1;
        if (pick >= 0) begin
          res.idle       = 1'b0;
          res.ran_id     = job_id_tbl[pick];
          res.switched   = !prev_ran_valid || prev_ran_id != job_id_tbl[pick];
          prev_ran_id    = job_id_tbl[pick];
          prev_ran_valid = 1'b1;
          job_left_tbl[pick] = job_left_tbl[pick] - 16'd1;
          if (job_left_tbl[pick] == 16'd0) begin
            span = sched_time - job_arr_tbl[pick];
            res.finished    = 1'b1;
            res.done_time   = sched_time;
            res.turnaround  = span;
            // only goes negative once time has saturated
            res.waiting     = (span >= 32'(job_burst_tbl[pick])) ?
                              span - 32'(job_burst_tbl[pick]) : 32'd0;
            jobs_done++;
          end
        end
        res.all_done = (jobs_done == jobs_loaded);
        res.time_now = sched_time;
        expected_ticks.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic check_tick();
    tick_result_t got;
    tick_result_t want;
    got.ran_id      = out_ch.ran_id;
    got.idle        = out_ch.idle;
    got.switched    = out_ch.switched;
    got.finished    = out_ch.finished;
    got.done_time   = out_ch.done_time;
    got.turnaround  = out_ch.turnaround;
    got.waiting     = out_ch.waiting;
    got.all_done    = out_ch.all_done;
    got.time_now    = out_ch.time_now;
    if (expected_ticks.size() == 0) begin
      report_mismatch($sformatf("tick result with none expected, ran_id %0h time %0d",
                                got.ran_id, got.time_now));
      return;
    end
    want = expected_ticks.pop_front();
    compare_field("ran_id", 32'(got.ran_id), 32'(want.ran_id));
    compare_field("idle", 32'(got.idle), 32'(want.idle));
    compare_field("switched", 32'(got.switched), 32'(want.switched));
    compare_field("finished", 32'(got.finished), 32'(want.finished));
    compare_field("done_time", got.done_time, want.done_time);
    compare_field("turnaround", got.turnaround, want.turnaround);
    compare_field("waiting", got.waiting, want.waiting);
    compare_field("all_done", 32'(got.all_done), 32'(want.all_done));
    compare_field("time_now", got.time_now, want.time_now);
    ticks_checked++;
    if (want.idle) idle_ticks++;
    if (want.finished) completions++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(cur_req);
        items_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && expected_ticks.size() != 0)) begin
          cur_req = pending_reqs.pop_front();
          in_ch.operation <= cur_req.op;
          in_ch.job_id    <= cur_req.id;
          in_ch.arrival   <= cur_req.arrival;
          in_ch.burst     <= cur_req.burst;
          in_ch.valid     <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
          send_gap <= send_steady ? 0 : $urandom_range(0, 14);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : result_side
    bit took;
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_wait    <= 0;
    end else begin
      took = out_ch.valid && out_ch.ready;
      if (took) check_tick();
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (took) begin
        if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
        w = recv_steady ? 0 : $urandom_range(0, 14);
        recv_wait    <= w;
        out_ch.ready <= (w == 0);
      end else if (recv_wait != 0) begin
        // stall cycles only count while a beat is on offer
        if (out_ch.valid) recv_wait <= recv_wait - 1;
        out_ch.ready <= (recv_wait == 1) && out_ch.valid;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long output hold-offs so ticks back up behind the result register
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && items_accepted >= 400 + 700 * holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d ticks still expected",
               cycle_count, expected_ticks.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_req(input logic [1:0] op, input logic [7:0] id,
                           input logic [31:0] arrival, input logic [15:0] burst,
                           input bit drain_first);
    sched_req_t r;
    r.op          = op;
    r.id          = id;
    r.arrival     = arrival;
    r.burst       = burst;
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
  endtask

  initial begin
    int phase;
    int njobs;
    int total;
    int nticks;
    int j;
    int w;
    logic [7:0]  id;
    logic [31:0] arr;
    logic [15:0] bur;

    // directed: empty table, tie on id, late arrival preempting, zero burst,
    // a job that never arrives, the unused code, idle ticks
    queue_req(OP_CLEAR, 8'd0, 32'd0, 16'd1, 1'b1);
    queue_req(OP_TICK, 8'd0, 32'd0, 16'd1, 1'b0);
    queue_req(OP_ADD, 8'd255, 32'd0, 16'd3, 1'b0);
    queue_req(OP_ADD, 8'd0, 32'd0, 16'd3, 1'b0);
    queue_req(OP_ADD, 8'd7, 32'd2, 16'd1, 1'b0);
    queue_req(OP_ADD, 8'd9, 32'd0, 16'd0, 1'b0);
    queue_req(OP_ADD, 8'd90, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    queue_req(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    for (j = 0; j < 11; j++) queue_req(OP_TICK, 8'd0, 32'd0, 16'd1, 1'b0);
    queue_req(OP_ADD, 8'd3, 32'd0, 16'd2, 1'b0);
    queue_req(OP_TICK, 8'd0, 32'd0, 16'd1, 1'b0);
    queue_req(OP_TICK, 8'd0, 32'd0, 16'd1, 1'b0);

    // random: mostly job sets run to completion, some full-range noise
    phase = 0;
    while (pending_reqs.size() < NUM_ITEMS) begin
      phase++;
      if ($urandom_range(0, 3) != 0) begin
        queue_req(OP_CLEAR, 8'($urandom_range(0, 255)), $urandom(),
                  16'($urandom_range(1, 65535)), (phase % 4) == 0);
        njobs = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20)
                                            : $urandom_range(1, 8);
        total = 0;
        for (j = 0; j < njobs; j++) begin
          // small id range makes duplicate ids and tie-breaks likely
          id  = $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                     : 8'($urandom_range(0, 255));
          arr = $urandom_range(0, 24);
          bur = 16'($urandom_range(1, 6));
          if ($urandom_range(0, 11) == 0) bur = 16'($urandom_range(1, 65535));
          else if ($urandom_range(0, 11) == 0) arr = $urandom();
          else total += int'(bur);
          queue_req(OP_ADD, id, arr, bur, 1'b0);
        end
        nticks = total + $urandom_range(0, 6);
        if (nticks > 60) nticks = 60;
        for (j = 0; j < nticks; j++) begin
          if ($urandom_range(0, 19) == 0)
            queue_req(OP_ADD, 8'($urandom_range(0, 15)), $urandom_range(0, 40),
                      16'($urandom_range(1, 4)), 1'b0);
          else if ($urandom_range(0, 49) == 0)
            queue_req(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom(),
                      16'($urandom_range(1, 65535)), 1'b0);
          queue_req(OP_TICK, 8'($urandom_range(0, 255)), $urandom(),
                    16'($urandom_range(1, 65535)), 1'b0);
        end
      end else begin
        njobs = $urandom_range(10, 20);
        for (j = 0; j < njobs; j++)
          queue_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    $urandom(), 16'($urandom_range(1, 65535)), 1'b0);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_ch.valid) @(posedge clk);
    for (w = 0; w < DRAIN_LIMIT && expected_ticks.size() != 0; w++) @(posedge clk);
    if (expected_ticks.size() != 0)
      report_mismatch($sformatf("%0d tick results never arrived", expected_ticks.size()));
    repeat (40) @(posedge clk);

    $display("run covered %0d requests: %0d ticks checked, %0d idle, %0d job completions",
             items_accepted, ticks_checked, idle_ticks, completions);
    $display("%0d adds dropped on a full table, %0d output hold-offs, %0d mismatches",
             adds_dropped, holds_done, err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
